@@ hdl/sc1kd_pkg.sv @@
package sc1kd_pkg;

    // Payload of one scan code transfer
    typedef struct packed {
        logic [7:0] raw_code;
    } scan_item_t;

    // Payload of one key message transfer
    typedef struct packed {
        logic       key_release;
        logic [6:0] key_char;
        logic       shift_held;
        logic       ctrl_held;
    } key_msg_t;

    // Bit position of the break flag in a scan code
    localparam int unsigned RELEASE_BIT = 7;

    // Make codes of the modifier keys
    localparam logic [6:0] MAKE_LSHIFT = 7'h2A;
    localparam logic [6:0] MAKE_RSHIFT = 7'h36;
    localparam logic [6:0] MAKE_CTRL   = 7'h1D;

    // Full codes that steer the prefix tracking
    localparam logic [7:0] CODE_EXT_PREFIX  = 8'hE0;
    localparam logic [7:0] CODE_PRTSC_ENT_A = 8'h2A;
    localparam logic [7:0] CODE_PRTSC_ENT_B = 8'hB7;
    localparam logic [7:0] CODE_PRTSC_END_A = 8'h37;
    localparam logic [7:0] CODE_PRTSC_END_B = 8'hAA;

    // Marks an unmapped make code
    localparam logic [6:0] CHAR_NONE = 7'h00;

    // Map a make code to its ASCII character, CHAR_NONE when unmapped
    function automatic logic [6:0] key_lookup(input logic [6:0] make);
        logic [6:0] ch;
        begin
            unique case (make)
                7'h01:   ch = 7'h1B;
                7'h02:   ch = 7'h31;
                7'h03:   ch = 7'h32;
                7'h04:   ch = 7'h33;
                7'h05:   ch = 7'h34;
                7'h06:   ch = 7'h35;
                7'h07:   ch = 7'h36;
                7'h08:   ch = 7'h37;
                7'h09:   ch = 7'h38;
                7'h0A:   ch = 7'h39;
                7'h0B:   ch = 7'h30;
                7'h0C:   ch = 7'h2D;
                7'h0D:   ch = 7'h3D;
                7'h0E:   ch = 7'h08;
                7'h0F:   ch = 7'h09;
                7'h10:   ch = 7'h51;
                7'h11:   ch = 7'h57;
                7'h12:   ch = 7'h45;
                7'h13:   ch = 7'h52;
                7'h14:   ch = 7'h54;
                7'h15:   ch = 7'h59;
                7'h16:   ch = 7'h55;
                7'h17:   ch = 7'h49;
                7'h18:   ch = 7'h4F;
                7'h19:   ch = 7'h50;
                7'h1C:   ch = 7'h0D;
                7'h1E:   ch = 7'h41;
                7'h1F:   ch = 7'h53;
                7'h20:   ch = 7'h44;
                7'h21:   ch = 7'h46;
                7'h22:   ch = 7'h47;
                7'h23:   ch = 7'h48;
                7'h24:   ch = 7'h4A;
                7'h25:   ch = 7'h4B;
                7'h26:   ch = 7'h4C;
                7'h27:   ch = 7'h3B;
                7'h28:   ch = 7'h27;
                7'h2B:   ch = 7'h5C;
                7'h2C:   ch = 7'h5A;
                7'h2D:   ch = 7'h58;
                7'h2E:   ch = 7'h43;
                7'h2F:   ch = 7'h56;
                7'h30:   ch = 7'h42;
                7'h31:   ch = 7'h4E;
                7'h32:   ch = 7'h4D;
                7'h35:   ch = 7'h2F;
                7'h39:   ch = 7'h20;
                default: ch = CHAR_NONE;
            endcase
            return ch;
        end
    endfunction

    // Replace a character by its shifted symbol where one applies
    function automatic logic [6:0] shifted_symbol(input logic [6:0] ch);
        logic [6:0] sym;
        begin
            unique case (ch)
                7'h39:   sym = 7'h28;
                7'h30:   sym = 7'h29;
                7'h38:   sym = 7'h2A;
                7'h2D:   sym = 7'h5F;
                7'h3D:   sym = 7'h2B;
                7'h27:   sym = 7'h22;
                7'h3B:   sym = 7'h3A;
                default: sym = ch;
            endcase
            return sym;
        end
    endfunction

endpackage

@@ hdl/sc1kd_stream_if.sv @@
interface sc1kd_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/scan_code_set1_key_decoder_top.sv @@
// Scan code set 1 key decoder.
// Channel scan (sink): one raw set 1 scan code per transfer.
// Channel key (source): one key message per mapped make or break code:
//   key_release, key_char (ASCII, letters upper case, shifted symbol applied),
//   shift_held and ctrl_held as they stood before the code.
// Prefix bytes and the codes that follow them, modifier codes, print-screen
// sequences and unmapped codes update the internal state and give no message.
// Path: a code taken on scan is held in the input register, and its decoded
// message is written into the result register, which drives key.
// Throughput: one code per cycle while key is not stalled; the prefix and
// modifier state is updated in the same cycle that the input register drains.
// Stall: while key is stalled the result register holds its message; the
// input register still drains codes that give no message, and scan.ready
// drops only when the input register holds a message and key is full.
// Reset (rst_n low, asynchronous): both registers empty, prefix tracking in
// the normal state, shift and ctrl released.
module scan_code_set1_key_decoder_top (
    input logic         clk,
    input logic         rst_n,
    sc1kd_stream_if.sink   scan,
    sc1kd_stream_if.source key
);

    typedef enum logic [1:0] {
        PFX_NORMAL = 2'd0,
        PFX_EXT    = 2'd1,
        PFX_PRTSC  = 2'd2
    } prefix_t;

    logic                  in_valid_reg;
    logic [7:0]            code_reg;
    prefix_t               pfx_reg;
    prefix_t               pfx_next;
    logic                  shift_reg;
    logic                  shift_next;
    logic                  ctrl_reg;
    logic                  ctrl_next;
    logic                  out_valid_reg;
    sc1kd_pkg::key_msg_t   out_data_reg;

    logic [6:0]            make;
    logic                  rel;
    logic [6:0]            base_char;
    logic                  hit;
    sc1kd_pkg::key_msg_t   msg;
    logic                  out_free;
    logic                  drain;
    logic                  take;

    assign make = code_reg[6:0];
    assign rel  = code_reg[sc1kd_pkg::RELEASE_BIT];
    assign base_char = sc1kd_pkg::key_lookup(make);

    // Decode the held code against the prefix and modifier state
    always_comb
    begin
        pfx_next   = pfx_reg;
        shift_next = shift_reg;
        ctrl_next  = ctrl_reg;
        hit        = 1'b0;
        msg.key_release = rel;
        msg.key_char    = shift_reg ? sc1kd_pkg::shifted_symbol(base_char) : base_char;
        msg.shift_held  = shift_reg;
        msg.ctrl_held   = ctrl_reg;
        unique case (pfx_reg)
            PFX_EXT:
            begin
                if (code_reg == sc1kd_pkg::CODE_PRTSC_ENT_A
                    || code_reg == sc1kd_pkg::CODE_PRTSC_ENT_B)
                begin
                    pfx_next = PFX_PRTSC;
                end
                else
                begin
                    if (make == sc1kd_pkg::MAKE_CTRL)
                    begin
                        ctrl_next = ~rel;
                    end
                    pfx_next = PFX_NORMAL;
                end
            end
            PFX_PRTSC:
            begin
                if (code_reg == sc1kd_pkg::CODE_PRTSC_END_A
                    || code_reg == sc1kd_pkg::CODE_PRTSC_END_B)
                begin
                    pfx_next = PFX_NORMAL;
                end
            end
            default:
            begin
                pfx_next = PFX_NORMAL;
                if (code_reg == sc1kd_pkg::CODE_EXT_PREFIX)
                begin
                    pfx_next = PFX_EXT;
                end
                else if (make == sc1kd_pkg::MAKE_LSHIFT || make == sc1kd_pkg::MAKE_RSHIFT)
                begin
                    shift_next = ~rel;
                end
                else if (make == sc1kd_pkg::MAKE_CTRL)
                begin
                    ctrl_next = ~rel;
                end
                else if (base_char != sc1kd_pkg::CHAR_NONE)
                begin
                    hit = 1'b1;
                end
            end
        endcase
    end

    // Drain the input register when its message has room or it has none
    assign out_free   = ~out_valid_reg | key.ready;
    assign drain      = in_valid_reg & (~hit | out_free);
    assign take       = scan.valid & scan.ready;
    assign scan.ready = ~in_valid_reg | drain;

    assign key.valid = out_valid_reg;
    assign key.data  = out_data_reg;

    // Hold input register, state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pfx_reg       <= PFX_NORMAL;
            shift_reg     <= 1'b0;
            ctrl_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (drain)
            begin
                in_valid_reg <= 1'b0;
            end

            if (drain)
            begin
                pfx_reg   <= pfx_next;
                shift_reg <= shift_next;
                ctrl_reg  <= ctrl_next;
            end

            if (drain && hit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (key.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            code_reg <= scan.data.raw_code;
        end
        if (drain && hit)
        begin
            out_data_reg <= msg;
        end
    end

    // A message only comes out of the normal prefix state
    a_hit_normal: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && hit) |-> (pfx_reg != PFX_EXT && pfx_reg != PFX_PRTSC))
        else $error("key message decoded outside the normal prefix state");

    // Input stalls only when a message waits behind a full result register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !scan.ready |-> (in_valid_reg && hit && out_valid_reg && !key.ready))
        else $error("scan channel stalled without a blocked message");

    // A new result always comes from a decoded message
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg && hit))
        else $error("result register filled without a decoded message");

    // A left shift make code in the normal state raises shift
    a_shift_set: assert property (@(posedge clk) disable iff (!rst_n)
        (drain && pfx_reg == PFX_NORMAL && !rel && make == sc1kd_pkg::MAKE_LSHIFT)
        |=> shift_reg)
        else $error("shift level not set by shift make code");

endmodule
